@@ design/qos_pkg.sv @@
// shared types and character codes for the query operator spacer
package qos_pkg;

   localparam int QOS_FIFO_DEPTH = 2;
   localparam int QOS_MAX_BYTES  = 8;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // expanded output of one item, byte 0 in the lowest bits
   typedef struct packed {
      logic [8*QOS_MAX_BYTES-1:0] bytes;
      logic [3:0]                 count;
      logic                       line_last;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

@@ design/qos_front.sv @@
// front end: classifies each byte, tracks modes and builds the expanded bytes
module qos_front import qos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       fifo_full,
   output push_type   push
);

   typedef struct packed {
      logic [31:0] bytes;
      logic [3:0]  len;
      logic        bars;
   } single_type;

   logic       in_string_ff, in_string_in;
   logic       in_bars_ff, in_bars_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_char_ff, held_char_in;

   function automatic logic passes(input logic [7:0] c);
      logic r;
      r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
          (c >= 8'h41 && c <= 8'h5A) || c == CH_DOT || c == CH_UNDER ||
          c == CH_HASH || c == CH_AT || c == CH_SPACE || c == CH_DOLLAR ||
          c == CH_SEMI;
      return r;
   endfunction

   function automatic logic may_start_pair(input logic [7:0] c);
      logic r;
      r = c == CH_BAR || c == CH_AMP || c == CH_CARET || c == CH_LT ||
          c == CH_GT || c == CH_BANG;
      return r;
   endfunction

   function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
      logic r;
      r = (a == CH_BAR && b == CH_BAR) || (a == CH_AMP && b == CH_AMP) ||
          (a == CH_CARET && b == CH_CARET) ||
          ((a == CH_LT || a == CH_GT || a == CH_BANG) && b == CH_EQ);
      return r;
   endfunction

   // a lone operator byte, padded with spaces; a bar flips bar mode
   function automatic single_type single(input logic [7:0] c, input logic bars);
      single_type s;
      s.bars = bars;
      if (c == CH_BAR) begin
         s.bars = ~bars;
         s.len  = 4'd4;
         if (s.bars) begin
            s.bytes = {CH_SPACE, CH_LBRACE, CH_BAR, CH_SPACE};
         end else begin
            s.bytes = {CH_SPACE, CH_BAR, CH_RBRACE, CH_SPACE};
         end
      end else begin
         s.len   = 4'd3;
         s.bytes = {8'h00, CH_SPACE, c, CH_SPACE};
      end
      return s;
   endfunction

   logic        accept;
   logic        pair_hit;
   logic [31:0] a_bytes, b_bytes;
   logic [3:0]  a_len, b_len;
   logic        bars_a;
   single_type  s_held, s_cur;

   assign req_tready = ~fifo_full;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      s_held        = single(held_char_ff, in_bars_ff);
      pair_hit      = held_valid_ff && is_pair(held_char_ff, req_tdata);
      in_string_in  = in_string_ff;
      held_valid_in = 1'b0;
      held_char_in  = 8'h00;
      a_bytes       = 32'h0;
      a_len         = 4'd0;
      bars_a        = in_bars_ff;
      b_bytes       = 32'h0;
      b_len         = 4'd0;
      if (pair_hit) begin
         a_bytes = {CH_SPACE, req_tdata, held_char_ff, CH_SPACE};
         a_len   = 4'd4;
      end else if (held_valid_ff) begin
         a_bytes = s_held.bytes;
         a_len   = s_held.len;
         bars_a  = s_held.bars;
      end
      s_cur      = single(req_tdata, bars_a);
      in_bars_in = bars_a;
      if (!pair_hit) begin
         priority if (req_tdata == CH_QUOTE) begin
            in_string_in = ~in_string_ff;
            b_bytes      = {24'h0, req_tdata};
            b_len        = 4'd1;
         end else if (in_string_ff || passes(req_tdata)) begin
            b_bytes = {24'h0, req_tdata};
            b_len   = 4'd1;
         end else if (may_start_pair(req_tdata) && !req_tlast) begin
            held_valid_in = 1'b1;
            held_char_in  = req_tdata;
         end else begin
            b_bytes    = s_cur.bytes;
            b_len      = s_cur.len;
            in_bars_in = s_cur.bars;
         end
      end
   end

   always_comb begin
      push.entry.bytes     = {32'h0, a_bytes} | ({32'h0, b_bytes} << {a_len, 3'b000});
      push.entry.count     = a_len + b_len;
      push.entry.line_last = req_tlast;
      // an item that only stores a pair start produces nothing
      push.valid           = accept && (push.entry.count != 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff  <= 1'b0;
         in_bars_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         held_char_ff  <= 8'h00;
      end else if (accept) begin
         in_string_ff  <= in_string_in;
         in_bars_ff    <= in_bars_in;
         held_valid_ff <= held_valid_in;
         held_char_ff  <= held_char_in;
      end
   end

   a_held_is_starter: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> may_start_pair(held_char_ff))
      else $error("held byte is not a pair start");

   a_line_end_flushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !held_valid_ff)
      else $error("byte still held after line end");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push.entry.count <= 4'd8)
      else $error("expanded item longer than eight bytes");

endmodule

@@ design/qos_fifo.sv @@
// short queue of expanded items between front and back
module qos_fifo import qos_pkg::*; #(
   parameter int FIFO_DEPTH = QOS_FIFO_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

   entry_type              slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full queue");

endmodule

@@ design/qos_back.sv @@
// back end: plays out the bytes of the head item one per cycle while rsp_tready is high
module qos_back import qos_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      empty,
   input  entry_type head,
   output logic      pop,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic      rsp_tlast,
   output logic [0:0] rsp_tuser
);

   logic [2:0] idx_ff, idx_in;
   logic       fin;
   logic       take;

   assign rsp_tvalid   = ~empty;
   assign rsp_tdata    = head.bytes[{idx_ff, 3'b000} +: 8];
   assign fin          = ({1'b0, idx_ff} == (head.count - 4'd1));
   assign rsp_tlast    = fin;
   assign rsp_tuser[0] = fin & head.line_last;
   assign take         = rsp_tvalid & rsp_tready;
   assign pop          = take & fin;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = fin ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> head.count != 4'd0)
      else $error("queued item with no bytes");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, idx_ff} < head.count)
      else $error("byte index past end of item");

endmodule

@@ design/query_operator_spacer_top.sv @@
// top level of the query operator spacer
// Respaces query text for word splitting: bytes enter on req_ one per item and leave on
// rsp_ one per item, with operators padded by spaces, two-byte operators kept joined and
// lone bars written as |{ or }|. An input byte produces n output bytes (0 to 8), sent one
// per output transfer; plain text passes through unchanged, so it flows at one item per
// cycle while rsp_tready is high. The figure is set by the back end, which sends one byte
// of the head queue entry per cycle. A possible operator start is
// held, producing nothing, until the next byte or the end of the line. A two-entry queue
// sits between the classifying front end and the output stage, so input is accepted
// whenever the queue has room. rsp_tlast marks the last byte caused by an input item.
module query_operator_spacer_top import qos_pkg::*; #(
   parameter int FIFO_DEPTH = QOS_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // ch
   input  logic       req_tlast,   // line_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char
   output logic       rsp_tlast,   // run_last
   output logic [0:0] rsp_tuser    // line_done
);

   push_type  push;
   entry_type head;
   logic      full, empty, pop;

   qos_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (full),
      .push       (push)
   );

   qos_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (full),
      .empty (empty),
      .head  (head)
   );

   qos_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/sv/query_operator_spacer_checker.sv @@
// checker for the query operator spacer: predicts respaced bytes and compares results
`timescale 1ns / 100ps

module query_operator_spacer_checker import qos_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // ch
   input  logic       req_tlast,   // line_last
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // out_char
   input  logic       rsp_tlast,   // run_last
   input  logic [0:0] rsp_tuser,   // line_done
   output int         fail_count,
   output int         outstanding
);

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       line_done;
   } spaced_char_type;

   spaced_char_type pending_chars[$];
   logic [7:0]      char_run[$];

   logic       in_string;
   logic       in_bars;
   logic       held_valid;
   logic [7:0] held_char;

   function automatic logic is_plain(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == CH_DOT || c == CH_UNDER || c == CH_HASH || c == CH_AT ||
             c == CH_SPACE || c == CH_DOLLAR || c == CH_SEMI;
   endfunction

   function automatic logic opens_pair(logic [7:0] c);
      return c == CH_BAR || c == CH_AMP || c == CH_CARET ||
             c == CH_LT || c == CH_GT || c == CH_BANG;
   endfunction

   function automatic logic joins(logic [7:0] a, logic [7:0] b);
      if (a == CH_BAR || a == CH_AMP || a == CH_CARET)
         return a == b;
      return (a == CH_LT || a == CH_GT || a == CH_BANG) && b == CH_EQ;
   endfunction

   task automatic add_char(input logic [7:0] c);
      char_run = {char_run, c};
   endtask

   // space, byte, space; a lone bar flips bar mode and becomes |{ or }|
   task automatic pad_single(input logic [7:0] c);
      add_char(CH_SPACE);
      if (c == CH_BAR) begin
         in_bars = !in_bars;
         if (in_bars) begin
            add_char(CH_BAR);
            add_char(CH_LBRACE);
         end else begin
            add_char(CH_RBRACE);
            add_char(CH_BAR);
         end
      end else begin
         add_char(c);
      end
      add_char(CH_SPACE);
   endtask

   task automatic respace_item(input logic [7:0] c, input logic last);
      logic       joined;
      logic [7:0] h;
      spaced_char_type sc;
      joined = 1'b0;
      char_run.delete();
      if (held_valid) begin
         h = held_char;
         held_valid = 1'b0;
         held_char = 8'd0;
         if (joins(h, c)) begin
            add_char(CH_SPACE);
            add_char(h);
            add_char(c);
            add_char(CH_SPACE);
            joined = 1'b1;
         end else begin
            pad_single(h);
         end
      end
      if (!joined) begin
         if (c == CH_QUOTE) begin
            in_string = !in_string;
            add_char(c);
         end else if (in_string || is_plain(c)) begin
            add_char(c);
         end else if (opens_pair(c) && !last) begin
            // wait for the next byte to see whether a pair forms
            held_valid = 1'b1;
            held_char = c;
         end else begin
            pad_single(c);
         end
      end
      for (int k = 0; k < char_run.size(); k++) begin
         sc.out_char  = char_run[k];
         sc.run_last  = (k == char_run.size() - 1);
         sc.line_done = (k == char_run.size() - 1) && last;
         pending_chars = {pending_chars, sc};
      end
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_char();
      spaced_char_type got;
      spaced_char_type want;
      got.out_char  = rsp_tdata;
      got.run_last  = rsp_tlast;
      got.line_done = rsp_tuser[0];
      if (pending_chars.size() == 0) begin
         report_mismatch($sformatf("unpredicted item char=%h last=%b done=%b",
                                   got.out_char, got.run_last, got.line_done));
      end else begin
         want = pending_chars.pop_front();
         if (got !== want)
            report_mismatch($sformatf("char=%h last=%b done=%b, want char=%h last=%b done=%b",
                                      got.out_char, got.run_last, got.line_done,
                                      want.out_char, want.run_last, want.line_done));
      end
   endtask

   // inputs first, so a result leaving in the same cycle finds its prediction
   always @(posedge clock) begin
      if (reset) begin
         in_string = 1'b0;
         in_bars = 1'b0;
         held_valid = 1'b0;
         held_char = 8'd0;
         pending_chars.delete();
      end else begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            respace_item(req_tdata, req_tlast);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            check_char();
      end
      outstanding = pending_chars.size();
   end

endmodule

@@ tb/sv/query_operator_spacer_top_tb.sv @@
// testbench top for the query operator spacer: stimulus, flow control and verdict
`timescale 1ns / 100ps

module query_operator_spacer_top_tb import qos_pkg::*;;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // ch
   logic       req_tlast;    // line_last
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // out_char
   logic       rsp_tlast;    // run_last
   logic [0:0] rsp_tuser;    // line_done

   int   fail_count;
   int   outstanding;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   bit   hold_long;
   bit   tx_busy;
   bit   rx_busy;
   int   sent_items;

   query_operator_spacer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   query_operator_spacer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // handshakes seen at the rising edge, read back at the falling edge
   always @(posedge clock) begin
      req_fire <= req_tvalid === 1'b1 && req_tready === 1'b1;
      rsp_fire <= rsp_tvalid === 1'b1 && rsp_tready === 1'b1;
   end

   task automatic send_item(input logic [7:0] c, input logic last);
      int gap;
      gap = tx_busy ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(negedge clock); while (!req_fire);
      sent_items++;
   endtask

   // stop offering until every predicted byte has left the block
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   task automatic send_token();
      logic [7:0] bytes[$];
      logic [7:0] b;
      int         idx;
      logic       end_line;
      string      plain_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._#@$;";
      string      pair_set  = "||&&^^<=>=!=";
      string      op_set    = "|&^<>!=";
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            repeat ($urandom_range(1, 6))
               bytes = {bytes, plain_set[$urandom_range(0, plain_set.len() - 1)]};
         end
         3: bytes = {bytes, CH_SPACE};
         4: begin
            idx = 2 * $urandom_range(0, 5);
            bytes = {bytes, pair_set[idx]};
            bytes = {bytes, pair_set[idx + 1]};
         end
         5: bytes = {bytes, op_set[$urandom_range(0, op_set.len() - 1)]};
         6: begin
            bytes = {bytes, CH_QUOTE};
            repeat ($urandom_range(0, 5)) begin
               b = 8'($urandom_range(0, 255));
               bytes = {bytes, (b == CH_QUOTE ? CH_SPACE : b)};
            end
            bytes = {bytes, CH_QUOTE};
         end
         7: begin
            bytes = {bytes, CH_BAR};
            bytes = {bytes, plain_set[$urandom_range(0, plain_set.len() - 1)]};
            bytes = {bytes, CH_BAR};
         end
         8: begin
            repeat ($urandom_range(1, 3))
               bytes = {bytes, 8'($urandom_range(0, 255))};
         end
         default: begin
            // operator start followed by anything, often a broken pair
            bytes = {bytes, op_set[$urandom_range(0, op_set.len() - 1)]};
            bytes = {bytes, 8'($urandom_range(0, 255))};
         end
      endcase
      end_line = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < bytes.size(); i++)
         send_item(bytes[i], end_line && i == bytes.size() - 1);
   endtask

   // result side: random stalls per item, plus one long hold-off on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      rx_busy = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (80) @(negedge clock);
            hold_long = 1'b0;
         end
         if ($urandom_range(0, 29) == 0)
            rx_busy = !rx_busy;
         gap = rx_busy ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_fire && !hold_long);
      end
   end

   initial begin
      bit did_hold;
      bit did_drain;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      hold_long = 1'b0;
      tx_busy = 1'b0;
      sent_items = 0;
      did_hold = 1'b0;
      did_drain = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item("a", 1'b0);
      send_item(CH_SPACE, 1'b0);
      send_item(CH_BAR, 1'b0);
      send_item(CH_BAR, 1'b0);
      send_item(CH_AMP, 1'b0);
      send_item(CH_AMP, 1'b0);
      send_item(CH_CARET, 1'b0);
      send_item(CH_CARET, 1'b0);
      send_item(CH_LT, 1'b0);
      send_item(CH_EQ, 1'b0);
      send_item(CH_GT, 1'b0);
      send_item(CH_EQ, 1'b0);
      send_item(CH_BANG, 1'b0);
      send_item(CH_EQ, 1'b0);
      // lone bars enter and leave bar mode
      send_item(CH_BAR, 1'b0);
      send_item("x", 1'b0);
      send_item(CH_BAR, 1'b0);
      // held byte flushed by another start, then a pair closing the line
      send_item(CH_LT, 1'b0);
      send_item(CH_LT, 1'b0);
      send_item(CH_EQ, 1'b1);
      // pair start on the last byte of a line
      send_item(CH_AMP, 1'b1);
      send_item(8'h00, 1'b0);
      // string left open across a line end
      send_item(CH_QUOTE, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(CH_QUOTE, 1'b0);
      send_item(8'h80, 1'b1);

      while (sent_items < 450) begin
         if (!did_hold && sent_items >= 150) begin
            did_hold = 1'b1;
            hold_long = 1'b1;
            tx_busy = 1'b0;
         end
         if (!did_drain && sent_items >= 300) begin
            did_drain = 1'b1;
            drain_results();
         end
         if (!hold_long && $urandom_range(0, 29) == 0)
            tx_busy = !tx_busy;
         send_token();
      end
      send_item("z", 1'b1);
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #3_200_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
